@@ rtl/dpsr_pkg.sv @@
// shared constants, types and width helpers for the decimal-precision square root
package dpsr_pkg;

    localparam int RADICAND_BITS_DEF = 31;
    localparam int MAX_DIGITS_DEF    = 8;
    localparam int DIGITS_W          = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCALE,
        ST_ROOT,
        ST_DONE
    } dpsr_state_t;

    // handshake between the top level and the sequencer
    typedef struct packed {
        logic idle;
        logic done;
    } dpsr_status_t;

    // 100 raised to a small power, evaluated at elaboration
    function automatic longint unsigned pow100(input int d);
        longint unsigned acc;
        acc = 64'd1;
        for (int i = 0; i < d; i++)
        begin
            acc = acc * 64'd100;
        end
        return acc;
    endfunction

    // width of the root of a radicand scaled by 100^max_digits
    function automatic int root_width(input int rad_bits, input int max_digits);
        int scaled_w;
        scaled_w = rad_bits + $clog2(pow100(max_digits));
        return (scaled_w + 1) >> 1;
    endfunction

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

@@ rtl/dpsr_in_if.sv @@
// request channel carrying the radicand and the decimal digit count
interface dpsr_in_if #(
    parameter int RADICAND_BITS = dpsr_pkg::RADICAND_BITS_DEF
);
    logic                            valid;
    logic                            ready;
    logic [RADICAND_BITS-1:0]        radicand;
    logic [dpsr_pkg::DIGITS_W-1:0]   digits;

    modport source (output valid, output radicand, output digits, input ready);
    modport sink   (input valid, input radicand, input digits, output ready);
endinterface

@@ rtl/dpsr_out_if.sv @@
// result channel carrying the scaled square root
interface dpsr_out_if #(
    parameter int ROOT_W = dpsr_pkg::root_width(dpsr_pkg::RADICAND_BITS_DEF,
                                                dpsr_pkg::MAX_DIGITS_DEF)
);
    logic              valid;
    logic              ready;
    logic [ROOT_W-1:0] root_scaled;

    modport source (output valid, output root_scaled, input ready);
    modport sink   (input valid, input root_scaled, output ready);
endinterface

@@ rtl/decimal_precision_square_root.sv @@
// top level: floor(sqrt(radicand * 100^digits)) with one shared add/subtract unit
// sequence: d = min(digits, MAX_DIGITS); 2*d steps of 10x scaling, then one root bit per cycle,
// then the root moves into the output register
// a new request is taken only once the previous root has left the core, later while a result
// waits unread
// reset (rst_n, async, active low) returns the sequencer to idle and empties the output
module decimal_precision_square_root #(
    parameter int RADICAND_BITS = dpsr_pkg::RADICAND_BITS_DEF,
    parameter int MAX_DIGITS    = dpsr_pkg::MAX_DIGITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    dpsr_in_if.sink     in_ch,
    dpsr_out_if.source  out_ch
);

    // root width follows from the radicand width and the largest digit count
    localparam int ROOT_W = dpsr_pkg::root_width(RADICAND_BITS, MAX_DIGITS);

    dpsr_pkg::dpsr_status_t status;
    logic [ROOT_W-1:0]      core_root;
    logic                   start;
    logic                   take;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [ROOT_W-1:0] out_root_reg, out_root_next;

    // new request only while the sequencer is idle
    assign in_ch.ready = status.idle;
    assign start       = in_ch.valid & in_ch.ready;

    // move the finished root into the output slot when it is free or being drained
    assign take = status.done & (~out_valid_reg | out_ch.ready);

    dpsr_core #(
        .RADICAND_BITS (RADICAND_BITS),
        .MAX_DIGITS    (MAX_DIGITS),
        .ROOT_W        (ROOT_W)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .radicand (in_ch.radicand),
        .digits   (in_ch.digits),
        .take     (take),
        .status   (status),
        .root     (core_root)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_root_next  = out_root_reg;
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (take)
        begin
            out_valid_next = 1'b1;
            out_root_next  = core_root;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        out_root_reg <= out_root_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.root_scaled = out_root_reg;

endmodule

@@ rtl/dpsr_core.sv @@
// sequencer and shared add/subtract unit: decimal scaling then restoring root
module dpsr_core #(
    parameter int RADICAND_BITS = dpsr_pkg::RADICAND_BITS_DEF,
    parameter int MAX_DIGITS    = dpsr_pkg::MAX_DIGITS_DEF,
    parameter int ROOT_W        = dpsr_pkg::root_width(RADICAND_BITS, MAX_DIGITS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [RADICAND_BITS-1:0]      radicand,
    input  logic [dpsr_pkg::DIGITS_W-1:0] digits,
    input  logic                          take,
    output dpsr_pkg::dpsr_status_t        status,
    output logic [ROOT_W-1:0]             root
);

    localparam int NW    = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 1;
    localparam int CNT_W = $clog2(dpsr_pkg::max_int(2 * MAX_DIGITS, ROOT_W) + 1);
    localparam logic [dpsr_pkg::DIGITS_W-1:0] DIG_MAX = dpsr_pkg::DIGITS_W'(MAX_DIGITS);
    localparam logic [CNT_W-1:0] ROOT_STEPS = CNT_W'(ROOT_W);
    localparam logic [CNT_W-1:0] CNT_ONE    = CNT_W'(1);

    dpsr_pkg::dpsr_state_t state_reg, state_next;
    logic [NW-1:0]    n_reg, n_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [dpsr_pkg::DIGITS_W-1:0] dig_sat;
    logic [CNT_W-1:0] scale_steps;

    // shared add/subtract unit
    logic [NW-1:0] alu_a, alu_b;
    logic          alu_sub;
    logic [NW:0]   alu_sum;
    logic          alu_carry;

    assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (NW+1)'(alu_sub);
    assign alu_carry = alu_sum[NW];

    assign dig_sat     = (digits > DIG_MAX) ? DIG_MAX : digits;
    assign scale_steps = CNT_W'({dig_sat, 1'b0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dpsr_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        alu_a      = '0;
        alu_b      = '0;
        alu_sub    = 1'b0;

        case (state_reg)
            dpsr_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    n_next    = NW'(radicand);
                    rem_next  = '0;
                    root_next = '0;
                    if (scale_steps == '0)
                    begin
                        cnt_next   = ROOT_STEPS;
                        state_next = dpsr_pkg::ST_ROOT;
                    end
                    else
                    begin
                        cnt_next   = scale_steps;
                        state_next = dpsr_pkg::ST_SCALE;
                    end
                end
            end
            dpsr_pkg::ST_SCALE:
            begin
                // n * 10 = n*8 + n*2
                alu_a  = n_reg << 3;
                alu_b  = n_reg << 1;
                n_next = alu_sum[NW-1:0];
                cnt_next = cnt_reg - CNT_ONE;
                if (cnt_reg == CNT_ONE)
                begin
                    cnt_next   = ROOT_STEPS;
                    state_next = dpsr_pkg::ST_ROOT;
                end
            end
            dpsr_pkg::ST_ROOT:
            begin
                // bring down two bits, try root*4 + 1
                alu_a   = NW'({rem_reg, n_reg[NW-1 -: 2]});
                alu_b   = NW'({root_reg, 2'b01});
                alu_sub = 1'b1;
                if (alu_carry)
                begin
                    rem_next  = alu_sum[REM_W-1:0];
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = alu_a[REM_W-1:0];
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                n_next   = n_reg << 2;
                cnt_next = cnt_reg - CNT_ONE;
                if (cnt_reg == CNT_ONE)
                begin
                    state_next = dpsr_pkg::ST_DONE;
                end
            end
            dpsr_pkg::ST_DONE:
            begin
                if (take)
                begin
                    state_next = dpsr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dpsr_pkg::ST_IDLE;
            end
        endcase
    end

    assign status.idle = (state_reg == dpsr_pkg::ST_IDLE);
    assign status.done = (state_reg == dpsr_pkg::ST_DONE);
    assign root        = root_reg;

endmodule

@@ test/dpsr_root_check.sv @@
// scoreboard module: predicts each scaled root and compares it with the result channel
module dpsr_root_check (
    input  logic clk,
    input  logic rst_n,
    dpsr_in_if   in_ch,
    dpsr_out_if  out_ch,
    output int   errors,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAD_W  = dpsr_pkg::RADICAND_BITS_DEF;
    localparam int ROOT_W = dpsr_pkg::root_width(dpsr_pkg::RADICAND_BITS_DEF,
                                                 dpsr_pkg::MAX_DIGITS_DEF);

    typedef struct packed {
        logic [RAD_W-1:0]              radicand;
        logic [dpsr_pkg::DIGITS_W-1:0] digits;
        logic [ROOT_W-1:0]             root;
    } root_entry_t;

    root_entry_t awaited_roots [$];
    root_entry_t head;
    int          fail_cnt = 0;

    // floor(sqrt(radicand * 100^places)), places saturated, found bit by bit from the top
    function automatic logic [ROOT_W-1:0] scaled_root(input logic [RAD_W-1:0] radicand,
                                                      input logic [dpsr_pkg::DIGITS_W-1:0] digits);
        logic [127:0] target;
        logic [127:0] trial_sq;
        logic [63:0]  root;
        logic [63:0]  trial;
        int           places;
        int           i;
        int           b;
        places = (int'(digits) > dpsr_pkg::MAX_DIGITS_DEF) ? dpsr_pkg::MAX_DIGITS_DEF
                                                           : int'(digits);
        target = 128'(radicand);
        for (i = 0; i < places; i++)
        begin
            target = target * 128'd100;
        end
        root = '0;
        for (b = ROOT_W - 1; b >= 0; b--)
        begin
            trial    = root | (64'd1 << b);
            trial_sq = 128'(trial) * 128'(trial);
            if (trial_sq <= target)
            begin
                root = trial;
            end
        end
        return root[ROOT_W-1:0];
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // results first: none can stem from a request taken at the same edge
            if (out_ch.valid && out_ch.ready)
            begin
                if (awaited_roots.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, actual %0d",
                             $time, out_ch.root_scaled);
                    fail_cnt++;
                end
                else
                begin
                    head = awaited_roots.pop_front();
                    if (out_ch.root_scaled !== head.root)
                    begin
                        $display("%0t: root_scaled for radicand %0d digits %0d: expected %0d, actual %0d",
                                 $time, head.radicand, head.digits, head.root,
                                 out_ch.root_scaled);
                        fail_cnt++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                awaited_roots.push_back('{in_ch.radicand, in_ch.digits,
                                          scaled_root(in_ch.radicand, in_ch.digits)});
            end
        end
        errors  <= fail_cnt;
        pending <= awaited_roots.size();
    end

endmodule

@@ test/testbench.sv @@
// top of the bench: clock, reset, request stimulus, result back-pressure and the verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAD_W       = dpsr_pkg::RADICAND_BITS_DEF;
    localparam int MAXD        = dpsr_pkg::MAX_DIGITS_DEF;
    localparam int QUIET_LIMIT = 5000;   // cycles with no handshake before giving up
    localparam int TAIL_CYCLES = 80;     // wait after the last drain before the verdict
    localparam int PHASE_REQS  = 300;

    logic clk;
    logic rst_n;

    int send_idle_pct;   // chance per cycle that the sender holds off
    int stall_pct;       // chance per cycle that the receiver stalls
    int errors;
    int pending;
    int quiet_cycles = 0;

    dpsr_in_if  in_ch ();
    dpsr_out_if out_ch ();

    decimal_precision_square_root dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    dpsr_root_check root_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .errors  (errors),
        .pending (pending)
    );

    // free-running 10 ns clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // result side: ready drops at random according to the current phase
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog: any stretch with no request and no result accepted is a hang
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("** decimal_precision_square_root: FAILED **");
            $finish;
        end
    end

    // present one request and hold it until it is taken; valid stays high on return
    task automatic send_request(input logic [RAD_W-1:0] radicand,
                                input logic [dpsr_pkg::DIGITS_W-1:0] digits);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.radicand <= radicand;
        in_ch.digits   <= digits;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // stop sending and wait until every outstanding result has come back
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        // pending is registered in the scoreboard, so let the last request land first
        repeat (2) @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        logic [RAD_W-1:0]              rad;
        logic [dpsr_pkg::DIGITS_W-1:0] dig;
        logic [31:0]                   base;
        int                            kind;
        int                            w;
        int                            ph;

        in_ch.valid    = 1'b0;
        in_ch.radicand = '0;
        in_ch.digits   = '0;
        send_idle_pct  = 0;
        stall_pct      = 0;
        rst_n          = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero, one, largest radicand, perfect squares and their neighbors,
        // digit counts at 0, 8 and above 8 (saturated)
        send_request('0, 4'd0);
        send_request('0, 4'd8);
        send_request('0, 4'd15);
        send_request(31'd1, 4'd0);
        send_request(31'd1, 4'd8);
        send_request(31'd1, 4'd15);
        send_request(31'd2, 4'd8);
        send_request(31'd2, 4'd12);
        send_request(31'd3, 4'd4);
        send_request(31'd4, 4'd3);
        send_request(31'd99, 4'd1);
        send_request(31'd100, 4'd2);
        send_request(31'd65536, 4'd0);
        send_request(31'd12345, 4'd6);
        send_request(31'h7FFF_FFFF, 4'd0);
        send_request(31'h7FFF_FFFF, 4'd8);
        send_request(31'h7FFF_FFFF, 4'd9);
        send_request(31'h7FFF_FFFF, 4'd15);
        send_request(31'd2147395600, 4'd8);   // 46340 squared
        send_request(31'd2147395599, 4'd8);
        send_request(31'd1073741824, 4'd8);
        send_request(31'd1073741823, 4'd7);
        send_request(31'h5555_5555, 4'd5);
        send_request(31'h2AAA_AAAA, 4'd10);
        drain_results();

        // random phases: free flow, slow sender, slow receiver, both slow
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 87; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 87; end
                default: begin send_idle_pct = 30; stall_pct = 30; end
            endcase
            repeat (PHASE_REQS)
            begin
                kind = $urandom_range(9);
                case (kind)
                    0, 1, 2, 3: rad = RAD_W'($urandom);
                    4, 5:
                    begin
                        // random bit length so that small roots show up often
                        w   = $urandom_range(1, RAD_W);
                        rad = RAD_W'($urandom & ((32'd1 << w) - 32'd1));
                    end
                    6:
                    begin
                        // perfect squares and one below them
                        base = $urandom_range(46340);
                        rad  = RAD_W'(base * base);
                        if ((base != 0) && $urandom_range(1))
                        begin
                            rad = rad - RAD_W'(1);
                        end
                    end
                    7:       rad = 31'h7FFF_FFFF - RAD_W'($urandom_range(1000));
                    8:       rad = RAD_W'($urandom_range(100));
                    default: rad = RAD_W'($urandom_range(1));
                endcase
                // mostly legal digit counts, some above the maximum
                if ($urandom_range(4) == 0)
                begin
                    dig = 4'($urandom_range(15));
                end
                else
                begin
                    dig = 4'($urandom_range(MAXD));
                end
                send_request(rad, dig);
            end
            // sender holds off until the block has returned everything
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if ((errors == 0) && (pending == 0))
        begin
            $display("** decimal_precision_square_root: PASSED **");
        end
        else
        begin
            $display("** decimal_precision_square_root: FAILED **");
        end
        $finish;
    end

endmodule
